### rtl/core/tour_annealing_move_engine_assert.svh
// ----------------------------------------------------------------------------
// tour annealing move engine assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TOUR_ANNEALING_MOVE_ENGINE_ASSERT_SVH
`define TOUR_ANNEALING_MOVE_ENGINE_ASSERT_SVH

// same-cycle implication
`define TAME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tame_pkg.sv
// ----------------------------------------------------------------------------
// tame_pkg
// types and fixed field widths of the tour annealing move engine
// ----------------------------------------------------------------------------
package tame_pkg;

  localparam int OP_W        = 3;
  localparam int POS_W       = 6;
  localparam int LOC_BITS    = 6;
  localparam int VALUE_W     = 32;
  localparam int TEMP_W      = 32;
  localparam int NLR_W       = 16;
  localparam int DELTA_W     = 40;
  localparam int TOUR_COST_W = 38;
  localparam int COUNT_W     = 7;
  localparam int COUNT_MIN   = 5;
  localparam int FRAC_SHIFT  = 24;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_COST = 3'd0,
    OP_LOAD_TOUR = 3'd1,
    OP_START_RUN = 3'd2,
    OP_PROPOSE   = 3'd3,
    OP_READ_BEST = 3'd4
  } op_t;

  localparam logic MOVE_REVERSE = 1'b0;
  localparam logic MOVE_ROTATE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RUN_COST,
    ST_RUN_COPY,
    ST_DELTA,
    ST_MUL1,
    ST_MUL2,
    ST_DECIDE,
    ST_APPLY,
    ST_MOVE_COST,
    ST_BEST_COPY,
    ST_READ,
    ST_FINISH
  } state_t;

endpackage

### rtl/core/tame_in_if.sv
// ----------------------------------------------------------------------------
// tame_in_if
// request channel: valid, ready and one request transaction
// ----------------------------------------------------------------------------
interface tame_in_if import tame_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [POS_W-1:0]     row;
  logic [POS_W-1:0]     col;
  logic [VALUE_W-1:0]   cost_value;
  logic [POS_W-1:0]     position;
  logic [LOC_BITS-1:0]  location;
  logic [POS_W-1:0]     move_start;
  logic [POS_W-1:0]     move_mid;
  logic [POS_W-1:0]     move_end;
  logic                 move_kind;
  logic [TEMP_W-1:0]    temperature;
  logic [NLR_W-1:0]     neg_log_random;

  modport source (
    output valid, op, row, col, cost_value, position, location,
           move_start, move_mid, move_end, move_kind, temperature, neg_log_random,
    input  ready
  );

  modport sink (
    input  valid, op, row, col, cost_value, position, location,
           move_start, move_mid, move_end, move_kind, temperature, neg_log_random,
    output ready
  );

endinterface

### rtl/core/tame_out_if.sv
// ----------------------------------------------------------------------------
// tame_out_if
// result channel: valid, ready and one result transaction
// ----------------------------------------------------------------------------
interface tame_out_if import tame_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic                    status;
  logic                    accepted;
  logic [DELTA_W-1:0]      cost_delta;
  logic [TOUR_COST_W-1:0]  tour_cost;
  logic [TOUR_COST_W-1:0]  best_cost;
  logic                    best_improved;
  logic [LOC_BITS-1:0]     best_location;

  modport source (
    output valid, status, accepted, cost_delta, tour_cost, best_cost,
           best_improved, best_location,
    input  ready
  );

  modport sink (
    input  valid, status, accepted, cost_delta, tour_cost, best_cost,
           best_improved, best_location,
    output ready
  );

endinterface

### rtl/core/tour_annealing_move_engine.sv
// ----------------------------------------------------------------------------
// tour_annealing_move_engine
// annealing move engine: cost matrix, double-banked tour and best tour in
// synchronous memories, walked by a hop pipeline and a copy sweep
// ----------------------------------------------------------------------------
// channel | dir | handshake     | transaction
// in_ch   | in  | valid/ready   | op, indices, cost, move span, temperature
// out_ch  | out | valid/ready   | status, accepted, delta, costs, best entry
// cfg     | in  | cfg_we        | location_count, clamped to 5..MAX_LOCATIONS
//
// loads, bad ops, bad spans and bad reads pass from dispatch to finish; read best
// adds a best-memory read; run start walks the tour cost, then copies the tour to
// best memory; a move walks its hops, multiplies twice and decides; an accepted
// move rewrites the tour into the other bank and walks its cost, and a new best
// copies it to best memory; a result waiting in the output register holds the
// next one in its last state; reset clears control and costs
// ----------------------------------------------------------------------------
`include "tour_annealing_move_engine_assert.svh"

module tour_annealing_move_engine import tame_pkg::*; #(
  parameter int MAX_LOCATIONS = 64,
  parameter int COST_BITS     = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  tame_in_if.sink            in_ch,
  tame_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int LOC_W = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
  localparam int IW    = (MAX_LOCATIONS > 130) ? $clog2(MAX_LOCATIONS + 1) : 8;
  localparam int TA_W  = LOC_W + 1;
  localparam int CA_W  = 2 * LOC_W;
  localparam int P1_W  = COUNT_W + TEMP_W;
  localparam int P2_W  = P1_W + NLR_W;

  logic [COST_BITS-1:0] cost_mem [2**CA_W];
  logic [LOC_BITS-1:0]  tour_mem [2**TA_W];
  logic [LOC_BITS-1:0]  best_mem [2**LOC_W];

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]     count_r;
  logic [OP_W-1:0]        op_r;
  logic [POS_W-1:0]       row_r, col_r, pos_r, s_r, m_r, e_r;
  logic [LOC_BITS-1:0]    loc_r;
  logic [COST_BITS-1:0]   val_r;
  logic                   kind_r;
  logic [TEMP_W-1:0]      temp_r;
  logic [NLR_W-1:0]       nlr_r;

  logic                   bank_r;
  logic [IW-1:0]          j_r;
  logic signed [DELTA_W-1:0] acc_r, delta_r;
  logic [TOUR_COST_W-1:0] cur_cost_r, low_cost_r;
  logic [P1_W-1:0]        prod1_r;
  logic [P2_W-1:0]        prod2_r;

  logic                   h1_v_r, h1_sub_r, h2_v_r, h2_sub_r;
  logic [COST_BITS-1:0]   cd_r;
  logic                   sw1_v_r, sw1_best_r;
  logic [LOC_W-1:0]       sw1_idx_r;
  logic [LOC_BITS-1:0]    ta_r, tb_r, bd_r;

  logic                   res_status_r, res_acc_r, res_impr_r;
  logic [LOC_BITS-1:0]    res_bloc_r;

  logic                   out_valid_r, out_status_r, out_acc_r, out_impr_r;
  logic [DELTA_W-1:0]     out_delta_r;
  logic [TOUR_COST_W-1:0] out_tcost_r, out_bcost_r;
  logic [LOC_BITS-1:0]    out_bloc_r;

  logic in_fire;
  logic hop_issue, sweep_issue, phase_done, out_load;
  logic [IW-1:0] total, sx, mx, ex, jx, cx, len1, hp, hq, src;
  logic          hsub, stale, move_ok, cost_ok, tour_ok, read_ok, take_move;
  logic [TA_W-1:0] rd_a, rd_b;
  logic [63:0]   lhs, rhs;

  assign in_fire = in_ch.valid && in_ch.ready;

  assign sx = IW'(s_r);
  assign mx = IW'(m_r);
  assign ex = IW'(e_r);
  assign cx = IW'(count_r);
  assign jx = j_r;

  assign cost_ok = (row_r < count_r) && (col_r < count_r);
  assign tour_ok = (pos_r < count_r) && (loc_r < count_r);
  assign read_ok = pos_r < count_r;
  assign move_ok = (s_r != '0) && (s_r < m_r) && (m_r < e_r) && (ex + IW'(2) <= cx);

  assign lhs = {1'b0, delta_r[DELTA_W-2:0], FRAC_SHIFT'(0)};
  assign rhs = 64'(prod2_r);
  assign take_move = delta_r[DELTA_W-1] || (lhs < rhs);

  // hop generator
  always_comb begin
    len1 = ex - sx + IW'(2);
    hp   = '0;
    hq   = '0;
    hsub = 1'b0;
    if (state_r != ST_DELTA) begin
      hp = jx;
      hq = jx + IW'(1);
    end else if (kind_r == MOVE_ROTATE) begin
      unique case (jx)
        IW'(0):  begin hp = sx - IW'(1); hq = sx;           hsub = 1'b1; end
        IW'(1):  begin hp = ex;          hq = ex + IW'(1);  hsub = 1'b1; end
        IW'(2):  begin hp = mx - IW'(1); hq = mx;           hsub = 1'b1; end
        IW'(3):  begin hp = sx - IW'(1); hq = mx;           end
        IW'(4):  begin hp = ex;          hq = sx;           end
        IW'(5):  begin hp = mx - IW'(1); hq = ex + IW'(1);  end
        default: begin hp = '0;          hq = '0;           end
      endcase
    end else if (jx < len1) begin
      hp   = sx - IW'(1) + jx;
      hq   = sx + jx;
      hsub = 1'b1;
    end else if (jx == len1) begin
      hp = sx - IW'(1);
      hq = ex;
    end else if (jx == len1 + IW'(1)) begin
      hp = sx;
      hq = ex + IW'(1);
    end else begin
      hp = ex - (jx - len1 - IW'(2));
      hq = hp - IW'(1);
    end
  end

  // source position of the rewritten tour
  always_comb begin
    src = jx;
    if (state_r == ST_APPLY && jx >= sx && jx <= ex) begin
      if (kind_r == MOVE_REVERSE) begin
        src = sx + ex - jx;
      end else if (jx - sx <= ex - mx) begin
        src = mx + (jx - sx);
      end else begin
        src = jx - (ex - mx + IW'(1));
      end
    end
  end

  always_comb begin
    unique case (state_r)
      ST_RUN_COST, ST_MOVE_COST: total = cx - IW'(1);
      ST_DELTA: total = (kind_r == MOVE_ROTATE) ? IW'(6) : ((ex - sx) << 1) + IW'(4);
      ST_RUN_COPY, ST_APPLY, ST_BEST_COPY: total = IW'(MAX_LOCATIONS);
      default: total = '0;
    endcase
  end

  assign rd_a  = hop_issue ? {bank_r, LOC_W'(hp)} : {bank_r, LOC_W'(src)};
  assign rd_b  = {bank_r, LOC_W'(hq)};
  assign stale = (ta_r >= MAX_LOCATIONS) || (tb_r >= MAX_LOCATIONS);

  // control outputs
  always_comb begin
    hop_issue   = 1'b0;
    sweep_issue = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_RUN_COST, ST_DELTA, ST_MOVE_COST: hop_issue = (j_r != total);
      ST_RUN_COPY, ST_APPLY, ST_BEST_COPY: sweep_issue = (j_r != total);
      ST_FINISH: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign phase_done = (j_r == total) && !h1_v_r && !h2_v_r && !sw1_v_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (op_r)
          OP_START_RUN: state_nxt = ST_RUN_COST;
          OP_PROPOSE:   state_nxt = move_ok ? ST_DELTA : ST_FINISH;
          OP_READ_BEST: state_nxt = read_ok ? ST_READ : ST_FINISH;
          default:      state_nxt = ST_FINISH;
        endcase
      end
      ST_RUN_COST:  if (phase_done) state_nxt = ST_RUN_COPY;
      ST_RUN_COPY:  if (phase_done) state_nxt = ST_FINISH;
      ST_DELTA:     if (phase_done) state_nxt = ST_MUL1;
      ST_MUL1:      state_nxt = ST_MUL2;
      ST_MUL2:      state_nxt = ST_DECIDE;
      ST_DECIDE:    state_nxt = take_move ? ST_APPLY : ST_FINISH;
      ST_APPLY:     if (phase_done) state_nxt = ST_MOVE_COST;
      ST_MOVE_COST: begin
        if (phase_done) begin
          state_nxt = (acc_r[TOUR_COST_W-1:0] < low_cost_r) ? ST_BEST_COPY : ST_FINISH;
        end
      end
      ST_BEST_COPY: if (phase_done) state_nxt = ST_FINISH;
      ST_READ:      state_nxt = ST_FINISH;
      ST_FINISH:    if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= COUNT_W'(COUNT_MIN);
      bank_r      <= 1'b0;
      j_r         <= '0;
      h1_v_r      <= 1'b0;
      h2_v_r      <= 1'b0;
      sw1_v_r     <= 1'b0;
      cur_cost_r  <= '0;
      low_cost_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_wdata < COUNT_W'(COUNT_MIN)) begin
          count_r <= COUNT_W'(COUNT_MIN);
        end else if (cfg_wdata > MAX_LOCATIONS) begin
          count_r <= COUNT_W'(MAX_LOCATIONS);
        end else begin
          count_r <= cfg_wdata;
        end
      end
      if (state_nxt != state_r) begin
        j_r <= '0;
      end else if (hop_issue || sweep_issue) begin
        j_r <= j_r + IW'(1);
      end
      h1_v_r  <= hop_issue;
      h2_v_r  <= h1_v_r && !stale;
      sw1_v_r <= sweep_issue;
      if (state_r == ST_APPLY && phase_done) bank_r <= !bank_r;
      if ((state_r == ST_RUN_COST || state_r == ST_MOVE_COST) && phase_done) begin
        cur_cost_r <= acc_r[TOUR_COST_W-1:0];
      end
      if ((state_r == ST_RUN_COPY && phase_done) ||
          (state_r == ST_MOVE_COST && phase_done && state_nxt == ST_BEST_COPY)) begin
        low_cost_r <= (state_r == ST_RUN_COPY) ? cur_cost_r : acc_r[TOUR_COST_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_ch.op;
      row_r  <= in_ch.row;
      col_r  <= in_ch.col;
      val_r  <= in_ch.cost_value[COST_BITS-1:0];
      pos_r  <= in_ch.position;
      loc_r  <= in_ch.location;
      s_r    <= in_ch.move_start;
      m_r    <= in_ch.move_mid;
      e_r    <= in_ch.move_end;
      kind_r <= in_ch.move_kind;
      temp_r <= in_ch.temperature;
      nlr_r  <= in_ch.neg_log_random;
    end
    h1_sub_r   <= hsub;
    h2_sub_r   <= h1_sub_r;
    sw1_idx_r  <= LOC_W'(j_r);
    sw1_best_r <= (state_r != ST_APPLY);
    if (state_nxt != state_r) begin
      acc_r <= '0;
    end else if (h2_v_r) begin
      acc_r <= h2_sub_r ? acc_r - DELTA_W'(cd_r) : acc_r + DELTA_W'(cd_r);
    end
    if (state_r == ST_DELTA && phase_done) delta_r <= acc_r;
    prod1_r <= P1_W'(count_r) * P1_W'(temp_r);
    prod2_r <= P2_W'(prod1_r) * P2_W'(nlr_r);
    if (state_r == ST_DISPATCH) begin
      res_acc_r  <= 1'b0;
      res_impr_r <= 1'b0;
      res_bloc_r <= '0;
      unique case (op_r)
        OP_LOAD_COST: res_status_r <= !cost_ok;
        OP_LOAD_TOUR: res_status_r <= !tour_ok;
        OP_START_RUN: res_status_r <= 1'b0;
        OP_PROPOSE:   res_status_r <= !move_ok;
        OP_READ_BEST: res_status_r <= !read_ok;
        default:      res_status_r <= 1'b1;
      endcase
      if (op_r != OP_PROPOSE || !move_ok) delta_r <= '0;
    end
    if (state_r == ST_DECIDE) res_acc_r <= take_move;
    if (state_r == ST_MOVE_COST && state_nxt == ST_BEST_COPY) res_impr_r <= 1'b1;
    if (state_r == ST_READ) res_bloc_r <= bd_r;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_acc_r    <= res_acc_r;
      out_delta_r  <= delta_r;
      out_tcost_r  <= cur_cost_r;
      out_bcost_r  <= low_cost_r;
      out_impr_r   <= res_impr_r;
      out_bloc_r   <= res_bloc_r;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == ST_DISPATCH && op_r == OP_LOAD_COST && cost_ok) begin
      cost_mem[{LOC_W'(row_r), LOC_W'(col_r)}] <= val_r;
    end
    cd_r <= cost_mem[{LOC_W'(ta_r), LOC_W'(tb_r)}];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DISPATCH && op_r == OP_LOAD_TOUR && tour_ok) begin
      tour_mem[{bank_r, LOC_W'(pos_r)}] <= loc_r;
    end else if (sw1_v_r && !sw1_best_r) begin
      tour_mem[{!bank_r, sw1_idx_r}] <= ta_r;
    end
    ta_r <= tour_mem[rd_a];
    tb_r <= tour_mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (sw1_v_r && sw1_best_r) begin
      best_mem[sw1_idx_r] <= ta_r;
    end
    bd_r <= best_mem[LOC_W'(pos_r)];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.cost_delta    = out_delta_r;
  assign out_ch.tour_cost     = out_tcost_r;
  assign out_ch.best_cost     = out_bcost_r;
  assign out_ch.best_improved = out_impr_r;
  assign out_ch.best_location = out_bloc_r;

  `TAME_ASSERT_NEXT(a_fire_busy, in_fire, state_r != ST_IDLE, "engine idle after request")
  `TAME_ASSERT_NOW(a_acc_ok, out_ch.valid && out_ch.accepted, !out_ch.status, "accepted with error")
  `TAME_ASSERT_NOW(a_impr_cost, out_ch.valid && out_ch.best_improved, (out_ch.best_cost == out_ch.tour_cost) && out_ch.accepted, "best mismatch")
  `TAME_ASSERT_NOW(a_one_walk, sw1_v_r, !h1_v_r && !h2_v_r, "sweep overlaps hop walk")

endmodule
